// ----- design/mdff_pkg.sv -----
// ============================================================================
// mdff_pkg
// Shared constants, codes and controller/datapath interface types for the
// MAC duplicate frame filter.
// ============================================================================
package mdff_pkg;

    localparam int HISTORY_DEPTH = 16;
    localparam int ADDR_BITS     = 64;
    localparam int IDX_W         = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;

    localparam int SEQ_W     = 8;
    localparam int TIME_W    = 32;
    localparam int MAX_AGE_W = 16;

    localparam logic [MAX_AGE_W-1:0] MAX_AGE_RESET = MAX_AGE_W'(20);
    localparam logic [IDX_W-1:0]     LAST_IDX      = IDX_W'(HISTORY_DEPTH - 1);

    localparam logic OP_CHECK    = 1'b0;
    localparam logic OP_REGISTER = 1'b1;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;       // capture the incoming beat, restart the scan
        logic scan_step;  // move the scan pointer to the next entry
        logic capture;    // scan finished: note whether the sender was found
        logic eval;       // work out the duplicate verdict
        logic shift;      // move entries back and write the new one at the front
        logic emit;       // copy the verdict into the output register
    } t_dp_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic match;      // entry under the scan pointer holds the sender
        logic last;       // scan pointer is at the oldest entry
        logic is_reg;     // the item in hand is a register operation
    } t_dp_status;

endpackage

// ----- design/mdff_ctrl.sv -----
// ============================================================================
// mdff_ctrl
// Controller of the duplicate frame filter: sequences accept, scan, verdict
// or table update, and hand-over to the output register.
// ============================================================================
module mdff_ctrl (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    output logic                  o_ready,
    output logic                  o_valid,
    input  logic                  i_ready,
    input  mdff_pkg::t_dp_status  i_status,
    output mdff_pkg::t_dp_cmd     o_cmd
);
    import mdff_pkg::*;

    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_SCAN  = 5'b00010,
        S_EVAL  = 5'b00100,
        S_SHIFT = 5'b01000,
        S_EMIT  = 5'b10000
    } t_state;

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;
    logic   out_free;

    assign o_ready  = (r_state == S_IDLE);
    assign o_valid  = r_out_valid;
    assign out_free = !r_out_valid || i_ready;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_SCAN;
                end
            end
            S_SCAN: begin
                if (i_status.match || i_status.last) begin
                    o_cmd.capture = 1'b1;
                    n_state       = i_status.is_reg ? S_SHIFT : S_EVAL;
                end else begin
                    o_cmd.scan_step = 1'b1;
                end
            end
            S_EVAL: begin
                o_cmd.eval = 1'b1;
                n_state    = S_EMIT;
            end
            S_SHIFT: begin
                o_cmd.shift = 1'b1;
                n_state     = S_EMIT;
            end
            S_EMIT: begin
                if (out_free) begin
                    o_cmd.emit = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        if (o_cmd.emit) begin
            n_out_valid = 1'b1;
        end else if (r_out_valid && i_ready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

endmodule

// ----- design/mdff_datapath.sv -----
// ============================================================================
// mdff_datapath
// Datapath of the duplicate frame filter: item registers, history table,
// scan pointer, age comparison and output register.
// ============================================================================
module mdff_datapath (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [mdff_pkg::MAX_AGE_W-1:0]    i_cfg_wdata,
    input  logic                              i_operation,
    input  logic [63:0]                       i_sender_address,
    input  logic [mdff_pkg::SEQ_W-1:0]        i_sequence_number,
    input  logic [mdff_pkg::TIME_W-1:0]       i_now_time,
    input  mdff_pkg::t_dp_cmd                 i_cmd,
    output mdff_pkg::t_dp_status              o_status,
    output logic                              o_is_duplicate
);
    import mdff_pkg::*;

    // Item in hand.
    logic                 r_op;
    logic [ADDR_BITS-1:0] r_addr;
    logic [SEQ_W-1:0]     r_seq;
    logic [TIME_W-1:0]    r_now;

    // History table, most recent entry at index 0.
    logic [ADDR_BITS-1:0] r_tab_sender [HISTORY_DEPTH];
    logic [TIME_W-1:0]    r_tab_time   [HISTORY_DEPTH];
    logic [SEQ_W-1:0]     r_tab_seq    [HISTORY_DEPTH];

    logic [IDX_W-1:0]     r_idx;
    logic                 r_found;
    logic                 r_dup;
    logic                 r_out_dup;
    logic [MAX_AGE_W-1:0] r_max_age;

    logic [TIME_W-1:0]    age;
    logic                 age_ok;
    logic                 dup_now;

    assign o_status.match  = (r_tab_sender[r_idx] == r_addr);
    assign o_status.last   = (r_idx == LAST_IDX);
    assign o_status.is_reg = (r_op == OP_REGISTER);

    assign age     = r_now - r_tab_time[r_idx];
    assign age_ok  = (r_max_age == '0) || (age <= TIME_W'(r_max_age));
    assign dup_now = r_found && (r_tab_seq[r_idx] == r_seq) && age_ok;

    assign o_is_duplicate = r_out_dup;

    // Item registers and verdict.
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op   <= i_operation;
            r_addr <= i_sender_address[ADDR_BITS-1:0];
            r_seq  <= i_sequence_number;
            r_now  <= i_now_time;
        end
        if (i_cmd.capture) begin
            r_found <= o_status.match;
        end
        if (i_cmd.eval) begin
            r_dup <= dup_now;
        end else if (i_cmd.shift) begin
            r_dup <= 1'b0;
        end
        if (i_cmd.emit) begin
            r_out_dup <= r_dup;
        end
    end

    // Scan pointer and configuration.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx     <= '0;
            r_max_age <= MAX_AGE_RESET;
        end else begin
            if (i_cmd.load) begin
                r_idx <= '0;
            end else if (i_cmd.scan_step) begin
                r_idx <= r_idx + IDX_W'(1);
            end
            if (i_cfg_we) begin
                r_max_age <= i_cfg_wdata;
            end
        end
    end

    // Table update: entries in front of the hit position move back one place. When
    // the sender is absent the scan stops at the oldest entry, which drops out.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < HISTORY_DEPTH; k++) begin
                r_tab_sender[k] <= '0;
                r_tab_time[k]   <= '0;
                r_tab_seq[k]    <= '0;
            end
        end else if (i_cmd.shift) begin
            for (int k = 1; k < HISTORY_DEPTH; k++) begin
                if (IDX_W'(k) <= r_idx) begin
                    r_tab_sender[k] <= r_tab_sender[k-1];
                    r_tab_time[k]   <= r_tab_time[k-1];
                    r_tab_seq[k]    <= r_tab_seq[k-1];
                end
            end
            r_tab_sender[0] <= r_addr;
            r_tab_time[0]   <= r_now;
            r_tab_seq[0]    <= r_seq;
        end
    end

endmodule

// ----- design/mac_duplicate_frame_filter.sv -----
// ============================================================================
// mac_duplicate_frame_filter
// Sequence number duplicate detection over a most-recent-first history table.
// ============================================================================
// Each input beat either checks a received frame against the history or
// registers its sender, sequence number and timestamp. A check walks the
// sixteen-entry table from the most recent entry, one entry per clock, and
// stops at the first entry holding the sender; it reports a duplicate when
// that entry's sequence number matches and either max_age is zero or the
// wrapping 32-bit age (now minus stored time) does not exceed max_age.
// A register walks the table the same way, then at once moves the
// entries in front of the sender's old entry (or all of them, dropping the
// oldest, if the sender is absent) back by one and writes the new entry at
// the front. Every input beat yields exactly one output beat; is_duplicate is
// always 0 for a register. An item passes through accept, the scan, a
// verdict or update step and hand-over to the output register, which waits
// while that register holds an untaken result. A new beat is accepted only
// after that hand-over; the output register lets it be accepted while the
// last result still waits to be taken. The table is cleared to zero at
// reset, so zero-address senders match the cleared entries. max_age is
// written through i_cfg_we and i_cfg_wdata and resets to 20; the user must
// write it only while the block is idle; the block does not enforce this.
// ============================================================================
module mac_duplicate_frame_filter (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [mdff_pkg::MAX_AGE_W-1:0]  i_cfg_wdata,
    input  logic                            i_valid,
    output logic                            o_ready,
    input  logic                            i_operation,
    input  logic [63:0]                     i_sender_address,
    input  logic [mdff_pkg::SEQ_W-1:0]      i_sequence_number,
    input  logic [mdff_pkg::TIME_W-1:0]     i_now_time,
    output logic                            o_valid,
    input  logic                            i_ready,
    output logic                            o_is_duplicate
);
    import mdff_pkg::*;

    t_dp_cmd    dp_cmd;
    t_dp_status dp_status;

    // Controller: owns the handshakes and steps the datapath.
    mdff_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .o_ready  (o_ready),
        .o_valid  (o_valid),
        .i_ready  (i_ready),
        .i_status (dp_status),
        .o_cmd    (dp_cmd)
    );

    // Datapath: history table, comparison and result register.
    mdff_datapath u_datapath (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cfg_we          (i_cfg_we),
        .i_cfg_wdata       (i_cfg_wdata),
        .i_operation       (i_operation),
        .i_sender_address  (i_sender_address),
        .i_sequence_number (i_sequence_number),
        .i_now_time        (i_now_time),
        .i_cmd             (dp_cmd),
        .o_status          (dp_status),
        .o_is_duplicate    (o_is_duplicate)
    );

endmodule
